@@ design/assert_macros.svh @@
// Assertion macros used by the framer datapath.
// Each macro samples on the rising edge of clock and is disabled while reset is high,
// unless its name says otherwise.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BSPF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define BSPF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/bspf_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stream packet framer package
// Shared constants, register indexes, header positions and the command,
// status, configuration and controller state types of the framer.
// ----------------------------------------------------------------------------
package bspf_pkg;

   localparam int MaxDataBytes = 32;
   localparam int ByteWidth    = 8;
   localparam int HeaderBytes  = 7;
   localparam int FillWidth    = $clog2(MaxDataBytes + 1);
   localparam int CountWidth   = FillWidth;
   localparam int AddrWidth    = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
   localparam int HdrIdxWidth  = $clog2(HeaderBytes);
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   localparam logic [2:0] RegReceiver   = 3'd0;
   localparam logic [2:0] RegSender     = 3'd1;
   localparam logic [2:0] RegRequest    = 3'd2;
   localparam logic [2:0] RegStartUpper = 3'd3;
   localparam logic [2:0] RegStartLower = 3'd4;
   localparam logic [2:0] RegInProgress = 3'd5;
   localparam logic [2:0] RegSuccess    = 3'd6;

   localparam logic [HdrIdxWidth-1:0] HdrStartUpper = HdrIdxWidth'(0);
   localparam logic [HdrIdxWidth-1:0] HdrStartLower = HdrIdxWidth'(1);
   localparam logic [HdrIdxWidth-1:0] HdrReceiver   = HdrIdxWidth'(2);
   localparam logic [HdrIdxWidth-1:0] HdrSender     = HdrIdxWidth'(3);
   localparam logic [HdrIdxWidth-1:0] HdrRequest    = HdrIdxWidth'(4);
   localparam logic [HdrIdxWidth-1:0] HdrStatus     = HdrIdxWidth'(5);
   localparam logic [HdrIdxWidth-1:0] HdrLength     = HdrIdxWidth'(HeaderBytes - 1);

   typedef struct packed {
      logic [ByteWidth-1:0] receiver_address;
      logic [ByteWidth-1:0] sender_address;
      logic [ByteWidth-1:0] request_code;
      logic [ByteWidth-1:0] start_byte_upper;
      logic [ByteWidth-1:0] start_byte_lower;
      logic [ByteWidth-1:0] code_in_progress;
      logic [ByteWidth-1:0] code_success;
   } bspf_cfg_type;

   typedef struct packed {
      logic in_ready;
      logic store;
      logic store_held;
      logic start_full;
      logic start_final;
      logic emit_hdr;
      logic emit_data;
   } bspf_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic in_end;
      logic held_end;
      logic fill_full;
      logic hdr_done;
      logic data_done;
      logic pkt_final;
      logic out_free;
   } bspf_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEADER,
      ST_DATA,
      ST_STORE
   } bspf_state_type;

endpackage

@@ design/bspf_if.sv @@
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Valid and ready channels for message bytes in and framed bytes out.
// ----------------------------------------------------------------------------
interface bspf_req_if import bspf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink (input valid, input data_byte, input message_end, output ready);
endinterface

interface bspf_rsp_if import bspf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 packet_end;
   logic                 run_last;

   modport source (output valid, output out_byte, output packet_end, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input packet_end, input run_last,
                 output ready);
endinterface

@@ design/bspf_csr.sv @@
// ----------------------------------------------------------------------------
// Framer configuration registers
// APB-style register file holding the header bytes and status codes.
// ----------------------------------------------------------------------------
module bspf_csr import bspf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output bspf_cfg_type            cfg
);

   bspf_cfg_type         cfg_ff;
   bspf_cfg_type         cfg_in;
   logic [2:0]           reg_index;
   logic [ByteWidth-1:0] wr_byte;
   logic [ByteWidth-1:0] rd_byte;

   assign pready    = 1'b1;
   assign reg_index = paddr[CsrAddrWidth-1:2];
   assign wr_byte   = pwdata[ByteWidth-1:0];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_index)
            RegReceiver:   cfg_in.receiver_address = wr_byte;
            RegSender:     cfg_in.sender_address   = wr_byte;
            RegRequest:    cfg_in.request_code     = wr_byte;
            RegStartUpper: cfg_in.start_byte_upper = wr_byte;
            RegStartLower: cfg_in.start_byte_lower = wr_byte;
            RegInProgress: cfg_in.code_in_progress = wr_byte;
            RegSuccess:    cfg_in.code_success     = wr_byte;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         RegReceiver:   rd_byte = cfg_ff.receiver_address;
         RegSender:     rd_byte = cfg_ff.sender_address;
         RegRequest:    rd_byte = cfg_ff.request_code;
         RegStartUpper: rd_byte = cfg_ff.start_byte_upper;
         RegStartLower: rd_byte = cfg_ff.start_byte_lower;
         RegInProgress: rd_byte = cfg_ff.code_in_progress;
         RegSuccess:    rd_byte = cfg_ff.code_success;
         default:       rd_byte = '0;
      endcase
   end

   assign prdata = CsrDataWidth'(rd_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/bspf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Framer controller
// State machine that sequences taking bytes, storing them and sending packets.
// ----------------------------------------------------------------------------
module bspf_ctrl import bspf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  bspf_status_type status,
   output bspf_cmd_type    cmd
);

   bspf_state_type state_ff;
   bspf_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.in_valid && (status.fill_full || status.in_end)) begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (status.out_free && status.hdr_done) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (status.out_free && status.data_done) begin
               state_in = status.pkt_final ? ST_IDLE : ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = status.held_end ? ST_HEADER : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_valid) begin
               if (status.fill_full) begin
                  cmd.start_full = 1'b1;
               end else begin
                  cmd.store       = 1'b1;
                  cmd.start_final = status.in_end;
               end
            end
         end
         ST_HEADER: cmd.emit_hdr  = status.out_free;
         ST_DATA:   cmd.emit_data = status.out_free;
         ST_STORE: begin
            cmd.store       = 1'b1;
            cmd.store_held  = 1'b1;
            cmd.start_final = status.held_end;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/bspf_datapath.sv @@
// ----------------------------------------------------------------------------
// Framer datapath
// Payload buffer, fill and position counters, header selection and the
// output byte register.
// ----------------------------------------------------------------------------
module bspf_datapath import bspf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bspf_cmd_type     cmd,
   output bspf_status_type  status,
   input  bspf_cfg_type     cfg,
   bspf_req_if.sink         req_if,
   bspf_rsp_if.source       rsp_if
);
   `include "assert_macros.svh"

   logic [ByteWidth-1:0]   mem [MaxDataBytes];

   logic [FillWidth-1:0]   fill_ff;
   logic [FillWidth-1:0]   fill_in;
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  count_in;
   logic [HdrIdxWidth-1:0] hdr_idx_ff;
   logic [HdrIdxWidth-1:0] hdr_idx_in;
   logic [CountWidth-1:0]  data_idx_ff;
   logic [CountWidth-1:0]  data_idx_in;
   logic                   success_ff;
   logic                   success_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   logic [ByteWidth-1:0]   byte_ff;
   logic                   end_ff;
   logic [ByteWidth-1:0]   rd_data_ff;
   logic [ByteWidth-1:0]   out_byte_ff;
   logic [ByteWidth-1:0]   out_byte_in;
   logic                   packet_end_ff;
   logic                   packet_end_in;
   logic                   run_last_ff;
   logic                   run_last_in;

   logic                   accept;
   logic                   out_free;
   logic [ByteWidth-1:0]   wr_data;
   logic [AddrWidth-1:0]   wr_addr;
   logic                   rd_en;
   logic [AddrWidth-1:0]   rd_addr;
   logic [CountWidth-1:0]  next_idx;
   logic [ByteWidth-1:0]   hdr_byte;
   logic                   hdr_done;
   logic                   data_done;

   assign accept    = req_if.valid && cmd.in_ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign hdr_done  = (hdr_idx_ff == HdrLength);
   assign data_done = (data_idx_ff == count_ff - CountWidth'(1));
   assign next_idx  = data_idx_ff + CountWidth'(1);

   assign status.in_valid  = req_if.valid;
   assign status.in_end    = req_if.message_end;
   assign status.held_end  = end_ff;
   assign status.fill_full = (fill_ff == FillWidth'(MaxDataBytes));
   assign status.hdr_done  = hdr_done;
   assign status.data_done = data_done;
   assign status.pkt_final = success_ff;
   assign status.out_free  = out_free;

   assign req_if.ready      = cmd.in_ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_byte   = out_byte_ff;
   assign rsp_if.packet_end = packet_end_ff;
   assign rsp_if.run_last   = run_last_ff;

   assign wr_data = cmd.store_held ? byte_ff : req_if.data_byte;
   assign wr_addr = fill_ff[AddrWidth-1:0];
   assign rd_en   = (cmd.emit_hdr && hdr_done) || cmd.emit_data;
   assign rd_addr = cmd.emit_data ? next_idx[AddrWidth-1:0] : '0;

   always_comb begin
      case (hdr_idx_ff)
         HdrStartUpper: hdr_byte = cfg.start_byte_upper;
         HdrStartLower: hdr_byte = cfg.start_byte_lower;
         HdrReceiver:   hdr_byte = cfg.receiver_address;
         HdrSender:     hdr_byte = cfg.sender_address;
         HdrRequest:    hdr_byte = cfg.request_code;
         HdrStatus:     hdr_byte = success_ff ? cfg.code_success : cfg.code_in_progress;
         HdrLength:     hdr_byte = ByteWidth'(count_ff);
         default:       hdr_byte = '0;
      endcase
   end

   always_comb begin
      fill_in     = fill_ff;
      count_in    = count_ff;
      hdr_idx_in  = hdr_idx_ff;
      data_idx_in = data_idx_ff;
      success_in  = success_ff;
      if (cmd.store) begin
         fill_in = fill_ff + FillWidth'(1);
      end
      if (cmd.start_full) begin
         fill_in    = '0;
         count_in   = CountWidth'(MaxDataBytes);
         success_in = 1'b0;
         hdr_idx_in = '0;
      end
      if (cmd.start_final) begin
         fill_in    = '0;
         count_in   = fill_ff + CountWidth'(1);
         success_in = 1'b1;
         hdr_idx_in = '0;
      end
      if (cmd.emit_hdr) begin
         hdr_idx_in = hdr_idx_ff + HdrIdxWidth'(1);
         if (hdr_done) begin
            data_idx_in = '0;
         end
      end
      if (cmd.emit_data) begin
         data_idx_in = next_idx;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      out_byte_in   = out_byte_ff;
      packet_end_in = packet_end_ff;
      run_last_in   = run_last_ff;
      if (cmd.emit_hdr) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = hdr_byte;
         packet_end_in = 1'b0;
         run_last_in   = 1'b0;
      end else if (cmd.emit_data) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = rd_data_ff;
         packet_end_in = data_done;
         run_last_in   = data_done && (success_ff || !end_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         count_ff     <= '0;
         hdr_idx_ff   <= '0;
         data_idx_ff  <= '0;
         success_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         hdr_idx_ff   <= hdr_idx_in;
         data_idx_ff  <= data_idx_in;
         success_ff   <= success_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_if.data_byte;
         end_ff  <= req_if.message_end;
      end
      out_byte_ff   <= out_byte_in;
      packet_end_ff <= packet_end_in;
      run_last_ff   <= run_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `BSPF_ASSERT(a_store_not_full,
      cmd.store |-> (fill_ff < FillWidth'(MaxDataBytes)),
      "A byte was stored into a full payload buffer.")
   `BSPF_ASSERT(a_emit_needs_room,
      (cmd.emit_hdr || cmd.emit_data) |-> out_free,
      "A framed byte overwrote one that was still waiting.")
   `BSPF_ASSERT(a_data_in_range,
      cmd.emit_data |-> (count_ff != '0) && (data_idx_ff < count_ff),
      "A data byte was sent beyond the packet length.")

endmodule

@@ design/byte_stream_packet_framer_unit.sv @@
// ----------------------------------------------------------------------------
// Byte stream packet framer
// Cuts a message into packets with a seven byte header and sends them out
// one byte per transaction.
// ----------------------------------------------------------------------------
// Message bytes arrive on req_if (data_byte, message_end marks the last byte).
// Framed bytes leave on rsp_if (out_byte, packet_end on the last byte of a
// packet, run_last on the last byte caused by one input transaction).
// The header bytes and status codes are set through the APB port. The user
// must write them only while idle; the block itself does not enforce it.
// A byte that sends nothing is stored while idle. A byte that closes a packet
// of n data bytes holds the input while the header and data go out, one framed
// byte per cycle while the receiver keeps up, into the single output register;
// a byte arriving at a full buffer sends the full packet first and is then
// stored from its holding register. The first framed byte is presented after
// the header state loads it. Reset clears the fill count, counters, state and
// output valid; the payload buffer needs no clearing. When the receiver
// stalls, the output register holds its byte and the sequencer waits.
// ----------------------------------------------------------------------------
module byte_stream_packet_framer_unit import bspf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   bspf_req_if.sink                req_if,
   bspf_rsp_if.source              rsp_if,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   bspf_cfg_type    cfg;
   bspf_cmd_type    cmd;
   bspf_status_type status;

   bspf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bspf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   bspf_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
